// ===== rtl/q15s_pkg.sv =====
`timescale 1ns / 1ps

package q15s_pkg;

  // Pipeline depth, output register included.
  localparam int NSTG = 10;

  // Angle constants, Q15.
  localparam int Q15_PI      = 102944;
  localparam int Q15_HALF_PI = 51472;
  localparam int Q15_TWO_PI  = 205888;

  // Two pi splits into 2^6 * RED_DIV; reduce the upper bits by RED_DIV.
  localparam int RED_SHIFT = 6;
  localparam int RED_DIV   = Q15_TWO_PI / (1 << RED_SHIFT);
  // Multiple of RED_DIV that lifts any shifted angle to a positive value.
  localparam int RED_OFS   = RED_DIV * 10431;
  // Reciprocal of RED_DIV scaled by 2^RED_QS, rounded down.
  localparam int RED_QS    = 27;
  localparam int RED_MUL   = (1 << RED_QS) / RED_DIV;

  // Fold boundary: above this the remainder wraps to r - 2pi.
  localparam int FOLD_HI   = Q15_PI + Q15_HALF_PI;

  // Polynomial coefficients, Q15.
  localparam logic signed [15:0] Q15_C3 = -16'sd5461;
  localparam logic signed [15:0] Q15_C5 = 16'sd273;

endpackage

// ===== rtl/q15_sine_polynomial.sv =====
`timescale 1ns / 1ps

// Q15 polynomial sine.
// Input channel: in_angle (signed Q15 radians, any 32-bit value) with
// in_valid / in_stall. A word is taken on a rising edge with in_valid high
// and in_stall low.
// Output channel: out_sine (signed Q15, saturated) with out_valid /
// out_stall. A word leaves on an edge with out_valid high and out_stall low.
// A taken word enters stage 0 and is registered in turn through stages 1
// to 9; out_valid is the valid bit of stage 9, the output register.
// Throughput: one word per cycle while in_stall is low, set by the
// ten-stage pipeline, one reduction, fold, multiply or sum step per stage.
// Stall: a stalled output holds its word; earlier stages keep filling
// bubbles, and in_stall rises only once every stage holds a word and the
// output is stalled. Nothing is lost or repeated.
// Reset: rst_n (synchronous, active low) clears every valid bit; no word
// is in flight afterwards. The data registers are not reset.
module q15_sine_polynomial
  import q15s_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_angle,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_sine
);

  // Valid bit per stage and the ready chain running back from the output.
  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG:0]   rdy;

  assign rdy[NSTG] = !out_stall;

  genvar gi;
  generate
    for (gi = 0; gi < NSTG; gi++) begin : g_rdy
      // A stage loads when it is empty or its word moves on.
      assign rdy[gi] = !v_r[gi] || rdy[gi+1];
    end
  endgenerate

  assign in_stall = !rdy[0];
  assign v_nxt    = {v_r[NSTG-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k < NSTG; k++) begin
        if (rdy[k]) begin
          v_r[k] <= v_nxt[k];
        end
      end
    end
  end

  // Stage 0: split the angle into low six bits and a shifted part, and
  // lift the shifted part by a multiple of the divisor so it is positive.
  logic signed [27:0] ysh;
  logic signed [27:0] u_sum;
  logic [26:0]        u0_nxt;
  logic [26:0]        u0_r;
  logic [5:0]         lo0_r;

  assign ysh    = 28'(in_angle >>> RED_SHIFT);
  assign u_sum  = ysh + 28'(RED_OFS);
  assign u0_nxt = u_sum[26:0];

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      u0_r  <= u0_nxt;
      lo0_r <= in_angle[5:0];
    end
  end

  // Stage 1: quotient estimate by reciprocal multiply; may be one short.
  logic [42:0] qprod;
  logic [14:0] q1_nxt;
  logic [14:0] q1_r;
  logic [26:0] u1_r;
  logic [5:0]  lo1_r;

  assign qprod  = 43'(u0_r) * 43'(RED_MUL);
  assign q1_nxt = qprod[RED_QS+14:RED_QS];

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      q1_r  <= q1_nxt;
      u1_r  <= u0_r;
      lo1_r <= lo0_r;
    end
  end

  // Stage 2: remainder against the estimate, below twice the divisor.
  logic [26:0] qd;
  logic [26:0] rdiff;
  logic [12:0] rem2_nxt;
  logic [12:0] rem2_r;
  logic [5:0]  lo2_r;

  assign qd       = 27'(q1_r) * 27'(RED_DIV);
  assign rdiff    = u1_r - qd;
  assign rem2_nxt = rdiff[12:0];

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      rem2_r <= rem2_nxt;
      lo2_r  <= lo1_r;
    end
  end

  // Stage 3: correct the remainder with one compare and subtract.
  logic [11:0] rm3_nxt;
  logic [11:0] rm3_r;
  logic [5:0]  lo3_r;

  assign rm3_nxt = (rem2_r >= 13'(RED_DIV)) ? 12'(rem2_r - 13'(RED_DIV)) : rem2_r[11:0];

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      rm3_r <= rm3_nxt;
      lo3_r <= lo2_r;
    end
  end

  // Stage 4: rebuild the remainder in [0, 2pi) and fold into
  // [-pi/2, pi/2]. The middle band maps to r - pi and flips the sign;
  // the top band wraps to r - 2pi. Exactly pi lands on zero, flipped.
  logic signed [18:0] rs;
  logic signed [18:0] xf;
  logic               flip4_nxt;
  logic signed [17:0] xr4_r;
  logic               flip4_r;

  assign rs = $signed({1'b0, rm3_r, lo3_r});

  always_comb begin
    if (rs <= 19'sd51472) begin
      xf        = rs;
      flip4_nxt = 1'b0;
    end else if (rs < 19'(FOLD_HI)) begin
      xf        = rs - 19'(Q15_PI);
      flip4_nxt = 1'b1;
    end else begin
      xf        = rs - 19'(Q15_TWO_PI);
      flip4_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      xr4_r   <= xf[17:0];
      flip4_r <= flip4_nxt;
    end
  end

  // Stage 5: x^2, floor-shifted.
  logic signed [35:0] sq;
  logic signed [17:0] p2_5_r;
  logic signed [17:0] xr5_r;
  logic               flip5_r;

  assign sq = xr4_r * xr4_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      p2_5_r  <= 18'(sq >>> 15);
      xr5_r   <= xr4_r;
      flip5_r <= flip4_r;
    end
  end

  // Stage 6: x^3.
  logic signed [35:0] pr3;
  logic signed [17:0] p3_6_r;
  logic signed [17:0] p2_6_r;
  logic signed [17:0] xr6_r;
  logic               flip6_r;

  assign pr3 = xr5_r * p2_5_r;

  always_ff @(posedge clk) begin
    if (rdy[6]) begin
      p3_6_r  <= 18'(pr3 >>> 15);
      p2_6_r  <= p2_5_r;
      xr6_r   <= xr5_r;
      flip6_r <= flip5_r;
    end
  end

  // Stage 7: x^5 and the cubic term.
  logic signed [35:0] pr5;
  logic signed [33:0] t3p;
  logic signed [19:0] p5_7_r;
  logic signed [15:0] t3_7_r;
  logic signed [17:0] xr7_r;
  logic               flip7_r;

  assign pr5 = p2_6_r * p3_6_r;
  assign t3p = p3_6_r * Q15_C3;

  always_ff @(posedge clk) begin
    if (rdy[7]) begin
      p5_7_r  <= 20'(pr5 >>> 15);
      t3_7_r  <= 16'(t3p >>> 15);
      xr7_r   <= xr6_r;
      flip7_r <= flip6_r;
    end
  end

  // Stage 8: quintic term and the partial sum.
  logic signed [35:0] t5p;
  logic signed [18:0] s8_nxt;
  logic signed [12:0] t5_8_r;
  logic signed [18:0] s8_r;
  logic               flip8_r;

  assign t5p    = p5_7_r * Q15_C5;
  assign s8_nxt = 19'(xr7_r) + 19'(t3_7_r);

  always_ff @(posedge clk) begin
    if (rdy[8]) begin
      t5_8_r  <= 13'(t5p >>> 15);
      s8_r    <= s8_nxt;
      flip8_r <= flip7_r;
    end
  end

  // Stage 9: final sum, sign flip, saturate into the output register.
  logic signed [19:0] sum;
  logic signed [20:0] sgn;
  logic signed [15:0] sat_nxt;
  logic signed [15:0] out_sine_r;

  assign sum = 20'(s8_r) + 20'(t5_8_r);
  assign sgn = flip8_r ? -21'(sum) : 21'(sum);

  always_comb begin
    if (sgn > 21'sd32767) begin
      sat_nxt = 16'sh7fff;
    end else if (sgn < -21'sd32768) begin
      sat_nxt = -16'sh8000;
    end else begin
      sat_nxt = sgn[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[9]) begin
      out_sine_r <= sat_nxt;
    end
  end

  assign out_valid = v_r[NSTG-1];
  assign out_sine  = out_sine_r;

`ifndef SYNTHESIS
  // Input backs up only when every stage holds a word and the output stalls.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (&v_r && out_stall))
    else $error("input stalled with a bubble in the pipeline");

  // Corrected remainder stays below the divisor.
  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[3] |-> (rm3_r < 12'(RED_DIV)))
    else $error("remainder not reduced");

  // Folded angle lies in [-pi/2, pi/2].
  a_fold_range: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[4] |-> (xr4_r <= 18'sd51472 && xr4_r >= -18'sd51472))
    else $error("folded angle out of range");

  // A word in stage 8 moves into stage 9 once stage 9 is ready.
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[8] && rdy[9]) |=> v_r[9])
    else $error("word lost between last two stages");
`endif

endmodule
